// ===== hdl/hpcc_pkg.sv =====
`timescale 1ns / 1ps

package hpcc_pkg;

	// phase codes
	localparam int PHASE_W = 2;
	localparam logic [PHASE_W-1:0] PH_DECIDE = 2'd0;
	localparam logic [PHASE_W-1:0] PH_PULSE  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_COAST  = 2'd2;

	// register file
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_FAR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MID   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_NEAR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COAST_MIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COAST_MAX   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DROP_THR    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE_MID    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE_NEAR   = 3'd7;

	localparam logic [15:0] RST_PULSE_FAR  = 16'd2000;
	localparam logic [15:0] RST_PULSE_MID  = 16'd500;
	localparam logic [15:0] RST_PULSE_NEAR = 16'd250;
	localparam logic [15:0] RST_COAST_MIN  = 16'd3000;
	localparam logic [15:0] RST_COAST_MAX  = 16'd20000;
	localparam logic [9:0]  RST_DROP_THR   = 10'd15;
	localparam logic [6:0]  RST_ZONE_MID   = 7'd70;
	localparam logic [6:0]  RST_ZONE_NEAR  = 7'd85;

	typedef struct packed {
		logic [15:0] pulse_far_ms;
		logic [15:0] pulse_mid_ms;
		logic [15:0] pulse_near_ms;
		logic [15:0] min_coast_ms;
		logic [15:0] max_coast_ms;
		logic [9:0]  drop_threshold_cdeg;
		logic [6:0]  far_limit_pct;
		logic [6:0]  mid_limit_pct;
	} cfg_t;

endpackage

// ===== hdl/hpcc_cfg.sv =====
`timescale 1ns / 1ps

module hpcc_cfg
	import hpcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_far_ms        <= RST_PULSE_FAR;
			cfg_q.pulse_mid_ms        <= RST_PULSE_MID;
			cfg_q.pulse_near_ms       <= RST_PULSE_NEAR;
			cfg_q.min_coast_ms        <= RST_COAST_MIN;
			cfg_q.max_coast_ms        <= RST_COAST_MAX;
			cfg_q.drop_threshold_cdeg <= RST_DROP_THR;
			cfg_q.far_limit_pct       <= RST_ZONE_MID;
			cfg_q.mid_limit_pct       <= RST_ZONE_NEAR;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_PULSE_FAR:  cfg_q.pulse_far_ms        <= cfg_wdata;
				CFG_PULSE_MID:  cfg_q.pulse_mid_ms        <= cfg_wdata;
				CFG_PULSE_NEAR: cfg_q.pulse_near_ms       <= cfg_wdata;
				CFG_COAST_MIN:  cfg_q.min_coast_ms        <= cfg_wdata;
				CFG_COAST_MAX:  cfg_q.max_coast_ms        <= cfg_wdata;
				CFG_DROP_THR:   cfg_q.drop_threshold_cdeg <= cfg_wdata[9:0];
				CFG_ZONE_MID:   cfg_q.far_limit_pct       <= cfg_wdata[6:0];
				CFG_ZONE_NEAR:  cfg_q.mid_limit_pct       <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/hpcc_core.sv =====
`timescale 1ns / 1ps

module hpcc_core
	import hpcc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  cfg_t               cfg,
	input  logic [31:0]        now_ms,
	input  logic signed [15:0] temp_cdeg,
	input  logic [14:0]        target_cdeg,
	input  logic               restart,
	output logic               heater_on,
	output logic [PHASE_W-1:0] pulse_phase
);

	logic [PHASE_W-1:0] phase_q;
	logic [31:0]        timer_start_q;
	logic [15:0]        pulse_width_q;
	logic signed [15:0] peak_q;
	logic               heater_q;

	logic [PHASE_W-1:0] phase_d;
	logic [31:0]        timer_start_d;
	logic [15:0]        pulse_width_d;
	logic signed [15:0] peak_d;
	logic               heater_d;

	logic [PHASE_W-1:0] phase_eff;
	logic               at_target;
	logic signed [22:0] scaled;
	logic [21:0]        mid_lim;
	logic [21:0]        near_lim;
	logic               far_zone;
	logic               mid_zone;
	logic [31:0]        elapsed;
	logic signed [15:0] peak_new;
	logic signed [16:0] drop;

	assign phase_eff = restart ? PH_DECIDE : phase_q;
	assign at_target = $signed({temp_cdeg[15], temp_cdeg}) >= $signed({2'b00, target_cdeg});

	// exact ratio test: temp*100 against pct*target
	assign scaled   = $signed({{7{temp_cdeg[15]}}, temp_cdeg}) * 23'sd100;
	assign mid_lim  = 22'(cfg.far_limit_pct * target_cdeg);
	assign near_lim = 22'(cfg.mid_limit_pct * target_cdeg);
	assign far_zone = scaled < $signed({1'b0, mid_lim});
	assign mid_zone = scaled < $signed({1'b0, near_lim});

	// wraps modulo 2^32
	assign elapsed  = now_ms - timer_start_q;
	assign peak_new = (temp_cdeg > peak_q) ? temp_cdeg : peak_q;
	assign drop     = $signed({peak_new[15], peak_new}) - $signed({temp_cdeg[15], temp_cdeg});

	always_comb begin
		phase_d       = phase_eff;
		timer_start_d = timer_start_q;
		pulse_width_d = restart ? 16'd0 : pulse_width_q;
		peak_d        = peak_q;
		heater_d      = restart ? 1'b0 : heater_q;
		if (at_target) begin
			heater_d      = 1'b0;
			phase_d       = PH_DECIDE;
			pulse_width_d = 16'd0;
		end else begin
			case (phase_eff)
				PH_PULSE: begin
					if (elapsed >= {16'd0, pulse_width_q}) begin
						heater_d      = 1'b0;
						peak_d        = temp_cdeg;
						timer_start_d = now_ms;
						phase_d       = PH_COAST;
					end
				end
				PH_COAST: begin
					heater_d = 1'b0;
					peak_d   = peak_new;
					if (elapsed >= {16'd0, cfg.min_coast_ms}) begin
						if (drop >= $signed({7'd0, cfg.drop_threshold_cdeg}) ||
						    elapsed >= {16'd0, cfg.max_coast_ms}) begin
							phase_d = PH_DECIDE;
						end
					end
				end
				default: begin
					if (far_zone)
						pulse_width_d = cfg.pulse_far_ms;
					else if (mid_zone)
						pulse_width_d = cfg.pulse_mid_ms;
					else
						pulse_width_d = cfg.pulse_near_ms;
					timer_start_d = now_ms;
					heater_d      = 1'b1;
					phase_d       = PH_PULSE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_DECIDE;
			timer_start_q <= 32'd0;
			pulse_width_q <= 16'd0;
			peak_q        <= 16'sd0;
			heater_q      <= 1'b0;
		end else if (step_en) begin
			phase_q       <= phase_d;
			timer_start_q <= timer_start_d;
			pulse_width_q <= pulse_width_d;
			peak_q        <= peak_d;
			heater_q      <= heater_d;
		end
	end

	assign heater_on   = heater_d;
	assign pulse_phase = phase_d;

endmodule

// ===== hdl/heater_pulse_coast_controller_top.sv =====
`timescale 1ns / 1ps
// path: an input transfer is held in the input register, and its result in the
// result register on the master side; one tick per cycle while m_tready holds;
// the regulator steps from the input register, so ticks may arrive back to back
// reset: arst_n is asynchronous, active low; clears the regulator state, both
// stage valids and restores the register defaults

module heater_pulse_coast_controller_top
	import hpcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// tick input
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// now_ms [31:0], temp_cdeg [47:32], target_cdeg [62:48], restart [63]
	input  logic [63:0]           s_tdata,
	// result output
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// heater_on [0], pulse_phase [2:1], zeros [7:3]
	output logic [7:0]            m_tdata
);

	cfg_t cfg;

	// input register
	logic               valid_s1;
	logic [31:0]        now_s1;
	logic signed [15:0] temp_s1;
	logic [14:0]        target_s1;
	logic               restart_s1;

	// result register
	logic               m_valid_q;
	logic               heater_on_q;
	logic [PHASE_W-1:0] pulse_phase_q;

	logic               step_en;
	logic               heater_nxt;
	logic [PHASE_W-1:0] phase_nxt;

	// the tick in the input register steps when the result register is free
	// or is being emptied in this cycle
	assign step_en  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || step_en;

	hpcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	hpcc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (step_en),
		.cfg         (cfg),
		.now_ms      (now_s1),
		.temp_cdeg   (temp_s1),
		.target_cdeg (target_s1),
		.restart     (restart_s1),
		.heater_on   (heater_nxt),
		.pulse_phase (phase_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload capture on each input transfer
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_s1     <= s_tdata[31:0];
			temp_s1    <= s_tdata[47:32];
			target_s1  <= s_tdata[62:48];
			restart_s1 <= s_tdata[63];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step_en) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			heater_on_q   <= heater_nxt;
			pulse_phase_q <= phase_nxt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, pulse_phase_q, heater_on_q};

endmodule
